@@ src/chg_pkg.sv @@
// ----------------------------------------------------------------------------
// Change dispenser package
// Shared types, constants and denomination tables for the change dispenser.
// ----------------------------------------------------------------------------
package chg_pkg;

   // Number of denominations in use, and the slot capacity of the 4-bit index.
   localparam int NUM_DENOMS = 15;
   localparam int SLOT_CAP   = 16;
   localparam int STOCK_W    = 16;

   localparam logic [STOCK_W-1:0] STOCK_MAX = 16'hFFFF;
   localparam logic [30:0]        PAID_MAX  = 31'h7FFF_FFFF;

   // Command codes of an input beat.
   localparam logic CMD_DEPOSIT = 1'b0;
   localparam logic CMD_SETTLE  = 1'b1;

   // Result kinds of an output beat.
   localparam logic KIND_ACK      = 1'b0;
   localparam logic KIND_DISPENSE = 1'b1;

   typedef struct packed {
      logic        cmd;
      logic [3:0]  denom_index;
      logic [9:0]  quantity;
      logic [26:0] amount_due;
   } chg_req_type;

   typedef struct packed {
      logic               result_kind;
      logic [3:0]         slot;
      logic [15:0]        pieces_out;
      logic [30:0]        paid_total;
      logic signed [31:0] change_left;
      logic               last;
   } chg_rsp_type;

   // Write request into the stock counters.
   typedef struct packed {
      logic               en;
      logic               add;
      logic [3:0]         addr;
      logic [STOCK_W-1:0] amount;
   } chg_stock_wr_type;

   // Operands of the shared arithmetic unit.
   typedef struct packed {
      logic [15:0]        mul_a;
      logic [15:0]        mul_b;
      logic               sub;
      logic signed [33:0] add_a;
      logic signed [33:0] add_b;
   } chg_alu_op_type;

   typedef struct packed {
      logic [31:0]        product;
      logic signed [33:0] sum;
   } chg_alu_res_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DEP_MUL,
      ST_DEP_ACK,
      ST_SET_MUL,
      ST_SET_CMP,
      ST_SET_DIV,
      ST_SET_EMIT
   } chg_state_type;

   // Value of each slot in grosz; slots without a denomination are worth zero.
   function automatic logic [15:0] denom_value(input logic [3:0] idx);
      logic [15:0] v;
      case (idx)
         4'd0:    v = 16'd50000;
         4'd1:    v = 16'd20000;
         4'd2:    v = 16'd10000;
         4'd3:    v = 16'd5000;
         4'd4:    v = 16'd2000;
         4'd5:    v = 16'd1000;
         4'd6:    v = 16'd500;
         4'd7:    v = 16'd200;
         4'd8:    v = 16'd100;
         4'd9:    v = 16'd50;
         4'd10:   v = 16'd20;
         4'd11:   v = 16'd10;
         4'd12:   v = 16'd5;
         4'd13:   v = 16'd2;
         4'd14:   v = 16'd1;
         default: v = 16'd0;
      endcase
      if ({1'b0, idx} >= 5'(NUM_DENOMS)) begin
         v = 16'd0;
      end
      return v;
   endfunction

   // Piece count of each slot after reset.
   function automatic logic [STOCK_W-1:0] stock_init(input logic [3:0] idx);
      logic [STOCK_W-1:0] n;
      case (idx)
         4'd0:    n = 16'd3;
         4'd1:    n = 16'd6;
         4'd2:    n = 16'd6;
         4'd3:    n = 16'd15;
         4'd4:    n = 16'd21;
         4'd5:    n = 16'd16;
         4'd6:    n = 16'd7;
         4'd7:    n = 16'd5;
         4'd8:    n = 16'd16;
         4'd9:    n = 16'd8;
         4'd10:   n = 16'd10;
         4'd11:   n = 16'd10;
         4'd12:   n = 16'd8;
         4'd13:   n = 16'd7;
         4'd14:   n = 16'd15;
         default: n = 16'd0;
      endcase
      if ({1'b0, idx} >= 5'(NUM_DENOMS)) begin
         n = 16'd0;
      end
      return n;
   endfunction

endpackage

@@ src/chg_stock_file.sv @@
// ----------------------------------------------------------------------------
// Change dispenser stock counters
// One piece counter per slot, loaded with the opening stock at reset.
// Deposits add with saturation, dispensing subtracts.
// ----------------------------------------------------------------------------
module chg_stock_file
   import chg_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic [3:0]             rd_addr,
   output logic [STOCK_W-1:0]     rd_data,
   input  chg_stock_wr_type       wr
);

   logic [STOCK_W-1:0] stock_ff [SLOT_CAP];
   logic [STOCK_W-1:0] wr_base;
   logic [STOCK_W:0]   add_sum;
   logic [STOCK_W-1:0] wr_data;

   assign rd_data = stock_ff[rd_addr];

   // Saturating add for deposits; plain subtract for dispensed pieces.
   always_comb begin
      wr_base = stock_ff[wr.addr];
      add_sum = {1'b0, wr_base} + {1'b0, wr.amount};
      if (wr.add) begin
         wr_data = add_sum[STOCK_W] ? STOCK_MAX : add_sum[STOCK_W-1:0];
      end else begin
         wr_data = wr_base - wr.amount;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOT_CAP; i++) begin
            stock_ff[i] <= stock_init(4'(i));
         end
      end else if (wr.en) begin
         stock_ff[wr.addr] <= wr_data;
      end
   end

endmodule

@@ src/chg_alu.sv @@
// ----------------------------------------------------------------------------
// Change dispenser arithmetic unit
// The one multiplier and the one add/subtract path that the sequencer reuses
// for deposit value, stock value compare and each restoring division step.
// ----------------------------------------------------------------------------
module chg_alu
   import chg_pkg::*;
(
   input  chg_alu_op_type  op,
   output chg_alu_res_type res
);

   // 16 x 16 product; the caller registers it before use.
   assign res.product = 32'(op.mul_a) * 32'(op.mul_b);

   // 34-bit signed adder; its sign bit serves as the compare result.
   assign res.sum = op.sub ? (op.add_a - op.add_b) : (op.add_a + op.add_b);

endmodule

@@ src/greedy_change_dispenser_core.sv @@
// ----------------------------------------------------------------------------
// Greedy change dispenser core
// Cash drawer with per-denomination stock, running total and greedy change.
// ----------------------------------------------------------------------------
// A deposit beat multiplies the quantity by the denomination value and
// returns one acknowledge with the new total. A settle beat walks the slots
// from the largest denomination down and returns one dispense line per slot,
// the last one flagged. Each slot multiplies stock by value, compares against
// the remaining change and emits the line when the whole stock can be given
// or nothing is owed; when the stock exceeds what is owed, a 16-step restoring
// division on the shared subtractor runs before the line for that slot.
// A stall on the result side holds a settle at each line it emits.
// The input side is stalled for the whole of an item; the output register
// lets the last result wait while the next item is taken.
// ----------------------------------------------------------------------------
module greedy_change_dispenser_core
   import chg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  chg_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output chg_rsp_type rsp_data
);

   chg_state_type      state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   chg_rsp_type        rsp_data_ff, rsp_data_in;
   logic [3:0]         idx_ff, idx_in;
   logic [9:0]         qty_ff, qty_in;
   logic [30:0]        paid_ff, paid_in;
   logic [30:0]        total_ff, total_in;
   logic signed [31:0] rem_ff, rem_in;
   logic [3:0]         slot_ff, slot_in;
   logic [3:0]         bit_ff, bit_in;
   logic [15:0]        quo_ff, quo_in;
   logic [15:0]        pieces_ff, pieces_in;
   logic [31:0]        prod_ff, prod_in;

   logic               out_free;
   logic               idx_ok;
   logic               last_slot;
   logic [3:0]         stock_addr;
   logic [STOCK_W-1:0] stock_rd;
   logic [15:0]        cur_value;
   logic [15:0]        quo_next;
   logic [30:0]        paid_sat;
   chg_stock_wr_type   stock_wr;
   chg_alu_op_type     alu_op;
   chg_alu_res_type    alu_res;

   chg_stock_file u_stock (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (stock_addr),
      .rd_data (stock_rd),
      .wr      (stock_wr)
   );

   chg_alu u_alu (
      .op  (alu_op),
      .res (alu_res)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Deposits address the slot given; a settle addresses the slot walked.
   assign stock_addr = (state_ff == ST_DEP_MUL || state_ff == ST_DEP_ACK) ? idx_ff : slot_ff;
   assign cur_value  = denom_value(stock_addr);
   assign idx_ok     = ({1'b0, idx_ff} < 5'(NUM_DENOMS));
   assign last_slot  = ({1'b0, slot_ff} == 5'(NUM_DENOMS - 1));

   // Division step result: set the quotient bit when the trial subtract held.
   assign quo_next = alu_res.sum[33] ? quo_ff : (quo_ff | (16'd1 << bit_ff));

   // Total after a deposit, held at its ceiling.
   assign paid_sat = (alu_res.sum[33:31] != 3'd0) ? PAID_MAX : alu_res.sum[30:0];

   // Operand selection for the shared unit.
   always_comb begin
      alu_op       = '0;
      alu_op.mul_b = cur_value;
      alu_op.mul_a = (state_ff == ST_DEP_MUL) ? {6'd0, qty_ff} : stock_rd;
      case (state_ff)
         ST_DEP_ACK: begin
            alu_op.sub   = 1'b0;
            alu_op.add_a = {3'd0, paid_ff};
            alu_op.add_b = {2'd0, prod_ff};
         end
         ST_SET_CMP: begin
            alu_op.sub   = 1'b1;
            alu_op.add_a = {{2{rem_ff[31]}}, rem_ff};
            alu_op.add_b = {2'd0, prod_ff};
         end
         ST_SET_DIV: begin
            alu_op.sub   = 1'b1;
            alu_op.add_a = {{2{rem_ff[31]}}, rem_ff};
            alu_op.add_b = {2'd0, ({16'd0, cur_value} << bit_ff)};
         end
         default: begin
            alu_op.sub = 1'b0;
         end
      endcase
   end

   // Sequencer: next state, datapath updates and result beats.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      idx_in       = idx_ff;
      qty_in       = qty_ff;
      paid_in      = paid_ff;
      total_in     = total_ff;
      rem_in       = rem_ff;
      slot_in      = slot_ff;
      bit_in       = bit_ff;
      quo_in       = quo_ff;
      pieces_in    = pieces_ff;
      prod_in      = prod_ff;
      stock_wr     = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               idx_in = req_data.denom_index;
               qty_in = req_data.quantity;
               if (req_data.cmd == CMD_SETTLE) begin
                  rem_in   = $signed({1'b0, paid_ff}) - $signed({5'd0, req_data.amount_due});
                  total_in = paid_ff;
                  slot_in  = 4'd0;
                  state_in = ST_SET_MUL;
               end else begin
                  state_in = ST_DEP_MUL;
               end
            end
         end

         ST_DEP_MUL: begin
            prod_in  = alu_res.product;
            state_in = ST_DEP_ACK;
         end

         ST_DEP_ACK: begin
            if (out_free) begin
               if (idx_ok) begin
                  paid_in         = paid_sat;
                  stock_wr.en     = 1'b1;
                  stock_wr.add    = 1'b1;
                  stock_wr.addr   = idx_ff;
                  stock_wr.amount = {6'd0, qty_ff};
               end
               rsp_valid_in            = 1'b1;
               rsp_data_in.result_kind = KIND_ACK;
               rsp_data_in.slot        = idx_ff;
               rsp_data_in.pieces_out  = 16'd0;
               rsp_data_in.paid_total  = idx_ok ? paid_sat : paid_ff;
               rsp_data_in.change_left = 32'sd0;
               rsp_data_in.last        = 1'b1;
               state_in                = ST_IDLE;
            end
         end

         ST_SET_MUL: begin
            prod_in  = alu_res.product;
            state_in = ST_SET_CMP;
         end

         ST_SET_CMP: begin
            if (rem_ff[31] || rem_ff == 32'sd0 || cur_value == 16'd0) begin
               // Nothing owed or nothing to give from this slot.
               pieces_in = 16'd0;
               state_in  = ST_SET_EMIT;
            end else if (!alu_res.sum[33]) begin
               // The whole stock fits into what is owed.
               pieces_in = stock_rd;
               rem_in    = alu_res.sum[31:0];
               state_in  = ST_SET_EMIT;
            end else begin
               // Fewer pieces than the stock: divide, quotient fits 16 bits.
               quo_in   = 16'd0;
               bit_in   = 4'(STOCK_W - 1);
               state_in = ST_SET_DIV;
            end
         end

         ST_SET_DIV: begin
            if (!alu_res.sum[33]) begin
               rem_in = alu_res.sum[31:0];
            end
            quo_in = quo_next;
            if (bit_ff == 4'd0) begin
               pieces_in = quo_next;
               state_in  = ST_SET_EMIT;
            end else begin
               bit_in = bit_ff - 4'd1;
            end
         end

         ST_SET_EMIT: begin
            if (out_free) begin
               stock_wr.en             = 1'b1;
               stock_wr.add            = 1'b0;
               stock_wr.addr           = slot_ff;
               stock_wr.amount         = pieces_ff;
               rsp_valid_in            = 1'b1;
               rsp_data_in.result_kind = KIND_DISPENSE;
               rsp_data_in.slot        = slot_ff;
               rsp_data_in.pieces_out  = pieces_ff;
               rsp_data_in.paid_total  = total_ff;
               rsp_data_in.change_left = rem_ff;
               rsp_data_in.last        = last_slot;
               if (last_slot) begin
                  paid_in  = 31'd0;
                  state_in = ST_IDLE;
               end else begin
                  slot_in  = slot_ff + 4'd1;
                  state_in = ST_SET_MUL;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         paid_ff      <= 31'd0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         paid_ff      <= paid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      idx_ff      <= idx_in;
      qty_ff      <= qty_in;
      total_ff    <= total_in;
      rem_ff      <= rem_in;
      slot_ff     <= slot_in;
      bit_ff      <= bit_in;
      quo_ff      <= quo_in;
      pieces_ff   <= pieces_in;
      prod_ff     <= prod_in;
   end

endmodule

@@ src/chg_checker.sv @@
// ----------------------------------------------------------------------------
// Change dispenser port checker
// Watches the ports of the dispenser core and flags inconsistent beats.
// ----------------------------------------------------------------------------
module chg_checker
   import chg_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input chg_req_type req_data,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input chg_rsp_type rsp_data
);

   // A stalled result beat stays offered and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   // An accepted input beat keeps the block busy in the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken again right after an accepted beat");

   // A deposit acknowledge is a single, final beat with no pieces or change.
   a_ack_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.result_kind == KIND_ACK |->
         rsp_data.last && rsp_data.pieces_out == 16'd0 && rsp_data.change_left == 32'sd0)
      else $error("malformed deposit acknowledge");

   // Only the line of the smallest denomination closes a settle.
   a_last_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.result_kind == KIND_DISPENSE |->
         rsp_data.last == ({1'b0, rsp_data.slot} == 5'(NUM_DENOMS - 1)))
      else $error("dispense line flagged last at the wrong slot");

   // An underpaid settle dispenses nothing.
   a_underpaid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.result_kind == KIND_DISPENSE && rsp_data.change_left < 0 |->
         rsp_data.pieces_out == 16'd0)
      else $error("pieces dispensed while change is negative");

endmodule

bind greedy_change_dispenser_core chg_checker u_chg_checker (.*);
